FILE: rtl/dcp_bsw_pkg.sv
// shared types and constants of the dcp block stream walker
package dcp_bsw_pkg;

  // walk phase codes
  localparam logic [2:0] PH_OPT   = 3'd0;
  localparam logic [2:0] PH_SUB   = 3'd1;
  localparam logic [2:0] PH_LENHI = 3'd2;
  localparam logic [2:0] PH_LENLO = 3'd3;
  localparam logic [2:0] PH_VALUE = 3'd4;
  localparam logic [2:0] PH_PAD   = 3'd5;

  // one result item
  typedef struct packed {
    logic [7:0]  block_option;
    logic [7:0]  block_suboption;
    logic [15:0] block_length;
    logic        value_valid;
    logic [7:0]  value_byte;
    logic [15:0] value_index;
    logic        block_end;
    logic        walk_end;
    logic        walk_ok;
  } result_t;

  // walker step outcome handed to the output stage
  typedef struct packed {
    logic    emit;
    result_t res;
  } step_t;

endpackage

FILE: rtl/dcp_bsw_if.sv
// stream interfaces for the input byte channel and the result channel
interface dcp_bsw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface dcp_bsw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  block_option;
  logic [7:0]  block_suboption;
  logic [15:0] block_length;
  logic        value_valid;
  logic [7:0]  value_byte;
  logic [15:0] value_index;
  logic        block_end;
  logic        walk_end;
  logic        walk_ok;

  modport source (
    output valid, output block_option, output block_suboption, output block_length,
    output value_valid, output value_byte, output value_index, output block_end,
    output walk_end, output walk_ok, input ready
  );
  modport sink (
    input valid, input block_option, input block_suboption, input block_length,
    input value_valid, input value_byte, input value_index, input block_end,
    input walk_end, input walk_ok, output ready
  );
endinterface

FILE: rtl/dcp_bsw_parse.sv
// block header and value walker: phase state and per-byte result logic
module dcp_bsw_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [7:0]         data_byte,
  input  logic               final_byte,
  output dcp_bsw_pkg::step_t step
);
  import dcp_bsw_pkg::*;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  opt_r, opt_nxt;
  logic [7:0]  sub_r, sub_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;
  logic        last;

  assign len_full = len_r | {8'h00, data_byte};
  assign cnt_inc  = cnt_r + 16'd1;
  assign last     = (cnt_inc == len_r);

  // next state and result for the byte at the input
  always_comb begin
    phase_nxt = phase_r;
    opt_nxt   = opt_r;
    sub_nxt   = sub_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    step      = '0;
    case (phase_r)
      PH_SUB: begin
        sub_nxt   = data_byte;
        phase_nxt = PH_LENHI;
      end
      PH_LENHI: begin
        len_nxt   = {data_byte, 8'h00};
        phase_nxt = PH_LENLO;
      end
      PH_LENLO: begin
        len_nxt = len_full;
        cnt_nxt = '0;
        if (len_full == 16'd0) begin
          // empty block gives one event
          step.emit                = 1'b1;
          step.res.block_option    = opt_r;
          step.res.block_suboption = sub_r;
          step.res.block_length    = len_full;
          step.res.block_end       = 1'b1;
          step.res.walk_end        = final_byte;
          step.res.walk_ok         = final_byte;
          phase_nxt                = PH_OPT;
        end else if (final_byte) begin
          // header closes the area, value missing
          step.emit                = 1'b1;
          step.res.block_option    = opt_r;
          step.res.block_suboption = sub_r;
          step.res.block_length    = len_full;
          step.res.walk_end        = 1'b1;
        end else begin
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        cnt_nxt                  = cnt_inc;
        step.emit                = 1'b1;
        step.res.block_option    = opt_r;
        step.res.block_suboption = sub_r;
        step.res.block_length    = len_r;
        step.res.value_valid     = 1'b1;
        step.res.value_byte      = data_byte;
        step.res.value_index     = cnt_r;
        step.res.block_end       = last;
        step.res.walk_end        = final_byte;
        step.res.walk_ok         = final_byte & last;
        if (last) begin
          phase_nxt = len_r[0] ? PH_PAD : PH_OPT;
        end
      end
      PH_PAD: begin
        phase_nxt = PH_OPT;
      end
      default: begin
        opt_nxt   = data_byte;
        sub_nxt   = '0;
        len_nxt   = '0;
        cnt_nxt   = '0;
        phase_nxt = PH_SUB;
      end
    endcase

    // end of area: report if nothing else did, then start over
    if (final_byte) begin
      if (!step.emit) begin
        step.emit         = 1'b1;
        step.res.walk_end = 1'b1;
        step.res.walk_ok  = 1'b1;
      end
      phase_nxt = PH_OPT;
      opt_nxt   = '0;
      sub_nxt   = '0;
      len_nxt   = '0;
      cnt_nxt   = '0;
    end
  end

  // walker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPT;
      opt_r   <= '0;
      sub_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      opt_r   <= opt_nxt;
      sub_r   <= sub_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/dcp_block_stream_walker.sv
// top level of the dcp block stream walker
//
// channel      dir  handshake      payload
// in_stream    in   valid/ready    data_byte, final_byte
// out_stream   out  valid/ready    block tags, value byte and index, end flags
//
// one byte is taken per cycle while not stalled; its result, if any, shows
// in the next cycle from the output register. walker state is phase, tag,
// length and count registers, updated by two compares and one 16-bit
// increment per byte. synchronous active-low reset returns the walk to the
// option byte. a held result stalls input only while out_stream.ready is low.
module dcp_block_stream_walker (
  input  logic          clk,
  input  logic          rst_n,
  dcp_bsw_in_if.sink    in_stream,
  dcp_bsw_out_if.source out_stream
);
  import dcp_bsw_pkg::*;

  logic    fire;
  step_t   step;
  logic    out_valid_r;
  result_t out_res_r;

  assign in_stream.ready = !out_valid_r || out_stream.ready;
  assign fire            = in_stream.valid && in_stream.ready;

  dcp_bsw_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .data_byte  (in_stream.data_byte),
    .final_byte (in_stream.final_byte),
    .step       (step)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && step.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step.emit) begin
      out_res_r <= step.res;
    end
  end

  // result fields
  assign out_stream.valid           = out_valid_r;
  assign out_stream.block_option    = out_res_r.block_option;
  assign out_stream.block_suboption = out_res_r.block_suboption;
  assign out_stream.block_length    = out_res_r.block_length;
  assign out_stream.value_valid     = out_res_r.value_valid;
  assign out_stream.value_byte      = out_res_r.value_byte;
  assign out_stream.value_index     = out_res_r.value_index;
  assign out_stream.block_end       = out_res_r.block_end;
  assign out_stream.walk_end        = out_res_r.walk_end;
  assign out_stream.walk_ok         = out_res_r.walk_ok;

endmodule
